// ----- rtl/shb_pkg.sv -----
package shb_pkg;

    // Field widths
    localparam int HASH_W  = 32;
    localparam int BYTE_W  = 8;

    // Defaults
    localparam int                 QUEUE_DEPTH_DEF  = 2;
    localparam logic [HASH_W-1:0]  BUCKET_COUNT_RST = HASH_W'(1999);

    // Key byte that ends a key
    localparam logic [BYTE_W-1:0]  KEY_TERM = '0;

    // Hash handed from the front end to the queue
    typedef struct packed {
        logic              valid;
        logic [HASH_W-1:0] hash;
    } t_hash_xfer;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Back end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // hash * 65599 + byte, with 65599 = 2^16 + 2^6 - 1, wrapping at 32 bits
    function automatic logic [HASH_W-1:0] hash_step(
        input logic [HASH_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [HASH_W-1:0] acc;
        acc = (h << 16) + (h << 6) - h;
        return acc + HASH_W'(b);
    endfunction

endpackage

// ----- rtl/shb_front.sv -----
module shb_front
    import shb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic [BYTE_W-1:0] i_key_byte,
    output t_hash_xfer        o_xfer
);

    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic              accept;
    logic              is_term;

    assign accept  = i_push && !i_full;
    assign is_term = (i_key_byte == KEY_TERM);

    // Fold byte into the running hash, clear it on a terminator
    always_comb begin
        n_hash = r_hash;
        if (accept) begin
            if (is_term) begin
                n_hash = '0;
            end else begin
                n_hash = hash_step(r_hash, i_key_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
        end else begin
            r_hash <= n_hash;
        end
    end

    // Transfer the finished hash to the queue on a terminator
    assign o_xfer.valid = accept && is_term;
    assign o_xfer.hash  = r_hash;

endmodule

// ----- rtl/shb_queue.sv -----
module shb_queue
    import shb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_hash_xfer        i_wr,
    input  logic              i_rd,
    output logic [HASH_W-1:0] o_rd_data,
    output t_queue_stat       o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [HASH_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_cnt;
    logic              do_wr;
    logic              do_rd;

    assign o_stat.full  = (r_cnt == CNT_FULL);
    assign o_stat.empty = (r_cnt == '0);
    assign do_wr        = i_wr.valid && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_rd_data    = r_mem[r_rd_ptr];

    // Store entry
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr.hash;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/shb_back.sv -----
module shb_back
    import shb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [HASH_W-1:0] i_cfg_data,
    input  t_queue_stat       i_q_stat,
    input  logic [HASH_W-1:0] i_q_data,
    output logic              o_q_rd,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [HASH_W-1:0] o_bucket_index,
    output logic [HASH_W-1:0] o_raw_hash
);

    localparam int CNT_W = $clog2(HASH_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HASH_W - 1);

    t_back_state       r_state;
    t_back_state       n_state;
    logic [HASH_W-1:0] r_bucket_count;
    logic [HASH_W-1:0] r_rem;
    logic [HASH_W-1:0] n_rem;
    logic [HASH_W-1:0] r_dvd;
    logic [HASH_W-1:0] n_dvd;
    logic [HASH_W-1:0] r_hash;
    logic [HASH_W-1:0] n_hash;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_out_valid;
    logic [HASH_W-1:0] r_out_bucket;
    logic [HASH_W-1:0] r_out_hash;
    logic              out_load;
    logic              pop_ok;
    logic [HASH_W:0]   rem_sh;
    logic [HASH_W:0]   diff;
    logic              rem_ge;

    // Bucket count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= BUCKET_COUNT_RST;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_data;
        end
    end

    // One restoring division step: shift in next dividend bit, try subtract
    assign rem_sh = {r_rem, r_dvd[HASH_W-1]};
    assign diff   = rem_sh - {1'b0, r_bucket_count};
    assign rem_ge = (rem_sh >= {1'b0, r_bucket_count});
    assign pop_ok = i_pop && r_out_valid;

    // Sequencer: take a hash, divide bit by bit, hand result to output register
    always_comb begin
        n_state  = r_state;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_hash   = r_hash;
        n_cnt    = r_cnt;
        o_q_rd   = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_q_rd  = 1'b1;
                    n_hash  = i_q_data;
                    n_dvd   = i_q_data;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = (r_bucket_count == '0) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                n_rem = rem_ge ? diff[HASH_W-1:0] : rem_sh[HASH_W-1:0];
                n_dvd = r_dvd << 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (!r_out_valid || pop_ok) begin
                    out_load = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_hash <= n_hash;
        r_cnt  <= n_cnt;
    end

    // Output register: hold result until popped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (pop_ok) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bucket <= r_rem;
            r_out_hash   <= r_hash;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_bucket_index = r_out_bucket;
    assign o_raw_hash     = r_out_hash;

endmodule

// ----- rtl/string_hash_bucket_index.sv -----
// String hash to bucket index.
// Input channel: present one key byte on i_key_byte with push high; the byte
// is transferred at a rising edge where full is low. A zero byte ends the
// key. Nonzero bytes are folded into a 32-bit running hash (hash*65599+byte)
// at one byte per cycle while full is low.
// Result channel: while empty is low, o_bucket_index (hash modulo bucket
// count) and o_raw_hash hold the oldest result; pop high transfers it.
// One result per terminator; an empty key gives bucket 0 and hash 0.
// Configuration: i_cfg_we writes i_cfg_data into the bucket count (reset
// 1999). A bucket count of zero gives bucket 0.
// After its terminator transfers, a hash is queued, read by the back end and
// divided; the result is loaded into the output register once that is free.
// The modulo is a restoring divider, one quotient bit per cycle; a short
// queue holds finished hashes so bytes of the next keys keep streaming in meanwhile.
// When the receiver stalls, the result holds, the back end waits, and full
// rises once the queue fills; nonzero bytes are then held off as well.
// Reset (synchronous, active low) clears the running hash, queue pointers,
// queue count, back end state and result valid flag; empty is high after reset.
module string_hash_bucket_index
    import shb_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] i_key_byte,
    output logic              empty,
    input  logic              pop,
    output logic [HASH_W-1:0] o_bucket_index,
    output logic [HASH_W-1:0] o_raw_hash,
    input  logic              i_cfg_we,
    input  logic [HASH_W-1:0] i_cfg_data
);

    t_hash_xfer        front_xfer;
    t_queue_stat       q_stat;
    logic [HASH_W-1:0] q_data;
    logic              q_rd;

    assign full = q_stat.full;

    shb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_full     (q_stat.full),
        .i_key_byte (i_key_byte),
        .o_xfer     (front_xfer)
    );

    shb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (front_xfer),
        .i_rd      (q_rd),
        .o_rd_data (q_data),
        .o_stat    (q_stat)
    );

    shb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_q_stat       (q_stat),
        .i_q_data       (q_data),
        .o_q_rd         (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_bucket_index (o_bucket_index),
        .o_raw_hash     (o_raw_hash)
    );

    // A terminator never hits a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_xfer.valid |-> !q_stat.full)
        else $error("hash transfer into full queue");

    // A transferred terminator leaves a hash waiting in the queue
    a_term_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !full && (i_key_byte == KEY_TERM)) |=> !q_stat.empty)
        else $error("terminator did not reach queue");

    // The back end only reads a non-empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_rd |-> !q_stat.empty)
        else $error("back end read from empty queue");

    // No result is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result pending after reset");

endmodule

// ----- verif/string_hash_bucket_index_tb.sv -----
`timescale 1ns / 100ps

module string_hash_bucket_index_tb;
    import shb_pkg::*;

    localparam logic [HASH_W-1:0] SDBM_MULT        = 32'd65599;
    localparam int                RESET_CYCLES     = 8;
    localparam int                DIV_LATENCY      = 34;
    localparam int                SETTLE_CYCLES    = DIV_LATENCY + 8;
    localparam int                HOLD_OFF_CYCLES  = 300;
    localparam int                STALL_LIMIT      = 3000;
    localparam int                NUM_PHASES       = 5;
    localparam int                PRESSURE_PHASE   = 4;
    localparam int                BYTES_PER_PHASE  = 265;
    localparam int                MAX_KEY_LEN      = 12;
    localparam int                LONG_KEY_LEN     = 40;

    typedef struct {
        logic [HASH_W-1:0] bucket;
        logic [HASH_W-1:0] hash;
    } t_key_result;

    // Running sdbm hash and the bucket results it owes the block
    class bucket_hash_tracker;
        logic [HASH_W-1:0] bucket_count;
        logic [HASH_W-1:0] running_hash;
        t_key_result       pending[$];
        int unsigned       errors;
        int unsigned       results_checked;

        function new();
            bucket_count    = BUCKET_COUNT_RST;
            running_hash    = '0;
            errors          = 0;
            results_checked = 0;
        endfunction

        function void set_bucket_count(logic [HASH_W-1:0] count);
            bucket_count = count;
        endfunction

        // Fold a byte in, or close the key on a terminator
        function void note_key_byte(logic [BYTE_W-1:0] key_byte);
            t_key_result res;
            if (key_byte != KEY_TERM) begin
                running_hash = running_hash * SDBM_MULT + HASH_W'(key_byte);
            end else begin
                res.hash   = running_hash;
                res.bucket = (bucket_count != '0) ? running_hash % bucket_count : '0;
                pending.push_back(res);
                running_hash = '0;
            end
        endfunction

        function void check_bucket_result(logic [HASH_W-1:0] bucket,
                                          logic [HASH_W-1:0] hash);
            t_key_result exp_res;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result bucket %0d hash %h", $time, bucket, hash);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            results_checked++;
            if (bucket !== exp_res.bucket) begin
                $display("%0t: bucket_index expected %0d actual %0d", $time,
                         exp_res.bucket, bucket);
                errors++;
            end
            if (hash !== exp_res.hash) begin
                $display("%0t: raw_hash expected %h actual %h", $time, exp_res.hash, hash);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] i_key_byte     = '0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [HASH_W-1:0] o_bucket_index;
    logic [HASH_W-1:0] o_raw_hash;
    logic              i_cfg_we       = 1'b0;
    logic [HASH_W-1:0] i_cfg_data     = '0;

    bucket_hash_tracker tracker = new();

    int          phase_id       = -1;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent     = 0;
    int unsigned keys_sent      = 0;
    int unsigned stall_cycles   = 0;

    string_hash_bucket_index i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_key_byte     (i_key_byte),
        .empty          (empty),
        .pop            (pop),
        .o_bucket_index (o_bucket_index),
        .o_raw_hash     (o_raw_hash),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort when no transfer happens on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next pop
    initial begin : result_sink
        int unsigned hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (pop && !empty) begin
                tracker.check_bucket_result(o_bucket_index, o_raw_hash);
            end
            // hold off long enough to fill the block and stall its input
            if (phase_id == PRESSURE_PHASE && !pressure_done) begin
                hold_left     = HOLD_OFF_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left != 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99, 0) >= recv_stall_pct);
            end
            @(posedge i_clk);
        end
    end

    // Offer one byte, idling at random first; push stays high on return
    task automatic send_key_byte(input logic [BYTE_W-1:0] key_byte);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push       <= 1'b1;
        i_key_byte <= key_byte;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        tracker.note_key_byte(key_byte);
        bytes_sent++;
        if (key_byte == KEY_TERM) keys_sent++;
    endtask

    task automatic send_random_key(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_key_byte(BYTE_W'($urandom_range(255, 1)));
        end
        send_key_byte(KEY_TERM);
    endtask

    task automatic send_repeated_key(input logic [BYTE_W-1:0] key_byte,
                                     input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_key_byte(key_byte);
        end
        send_key_byte(KEY_TERM);
    endtask

    // Stop offering, wait for every result and let the divider settle
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(input logic [HASH_W-1:0] count);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tracker.set_bucket_count(count);
    endtask

    initial begin : stimulus
        logic [HASH_W-1:0] phase_count[NUM_PHASES];
        int unsigned       phase_idle[NUM_PHASES];
        int unsigned       phase_stall[NUM_PHASES];
        int unsigned       phase_start;
        int unsigned       pick;

        phase_count = '{32'd1999, 32'hFFFF_FFFF, 32'd1, HASH_W'($urandom()),
                        HASH_W'($urandom_range(64, 2))};
        phase_idle  = '{0, 77, 0, 12, 0};
        phase_stall = '{0, 0, 77, 12, 0};

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed keys at the reset bucket count
        send_key_byte(KEY_TERM);
        send_repeated_key(8'hFF, 1);
        send_repeated_key(8'h01, 1);
        send_key_byte(8'h80);
        send_repeated_key(8'h7F, 1);
        send_repeated_key(8'hFF, 6);
        drain_results();

        // Zero bucket count reports bucket 0 with the hash intact
        write_bucket_count('0);
        send_repeated_key(8'hFF, 2);
        send_key_byte(KEY_TERM);
        drain_results();

        write_bucket_count(32'hFFFF_FFFF);
        send_repeated_key(8'hFF, 4);
        drain_results();

        write_bucket_count(32'd1);
        send_repeated_key(8'hA5, 1);
        drain_results();

        // Random phases: mostly well-formed keys, some stray bytes
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_bucket_count(phase_count[p]);
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            phase_id       = p;
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                pick = $urandom_range(99, 0);
                if (pick < 85) begin
                    send_random_key($urandom_range(MAX_KEY_LEN, 0));
                end else if (pick < 90) begin
                    send_random_key($urandom_range(LONG_KEY_LEN, MAX_KEY_LEN));
                end else begin
                    send_key_byte(BYTE_W'($urandom_range(255, 0)));
                end
            end
            send_key_byte(KEY_TERM);
            drain_results();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        if (tracker.pending.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.pending.size());
            tracker.errors++;
        end
        $display("Run: %0d key bytes in %0d keys, %0d bucket results checked",
                 bytes_sent, keys_sent, tracker.results_checked);
        $display("Bucket counts covered zero, one, all-ones and random, under varied idling");
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
